@@ hw/rtl/cvsd_decoder_top_defines.svh @@
`ifndef CVSD_DECODER_TOP_DEFINES_SVH
`define CVSD_DECODER_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define CVSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// implication into the next cycle outside reset
`define CVSD_ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

@@ hw/rtl/cvsd_pkg.sv @@
`timescale 1ns / 1ps

package cvsd_pkg;

   localparam int MUL_A_W  = 24;
   localparam int MUL_B_W  = 16;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int STEP_W   = 17;
   localparam int INT_W    = 24;
   localparam int DIVD_W   = 38;
   localparam int QUO_W    = 15;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MASK     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_COEFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_COEFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_COEFF   = 3'd4;

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_CLOCK = 1'b1;

   localparam logic [STEP_W-1:0]   STEP_MIN    = 17'd2726;
   localparam logic [STEP_W-1:0]   STEP_MAX    = 17'd71788;
   localparam logic [MUL_B_W-1:0]  GAIN_K      = 16'd10000;
   localparam logic [INT_W-1:0]    INT_POS_MAX = 24'h7FFFFF;
   localparam logic [INT_W-1:0]    INT_NEG_LIM = 24'h800000;
   localparam logic [DIVD_W-1:0]   DIV_BIAS    = 38'h0080000000;

   localparam logic        RST_ACTIVE_HIGH  = 1'b1;
   localparam logic [7:0]  RST_RUN_MASK     = 8'd7;
   localparam logic [15:0] RST_CHARGE_COEFF = 16'd64520;
   localparam logic [15:0] RST_DECAY_COEFF  = 16'd64520;
   localparam logic [15:0] RST_LEAK_COEFF   = 16'd61565;

   typedef struct packed {
      logic cmd;
      logic level;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       updated;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAK,
      ST_STEP,
      ST_GAIN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

endpackage

@@ hw/rtl/cvsd_mul.sv @@
`timescale 1ns / 1ps

module cvsd_mul (
   input  logic                                clock,
   input  cvsd_pkg::mul_req_type               mul_req,
   output logic [cvsd_pkg::PROD_W-1:0]         prod
);
   import cvsd_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_req.en) begin
         prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hw/rtl/cvsd_div.sv @@
`timescale 1ns / 1ps

module cvsd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cvsd_pkg::DIVD_W-1:0]   dividend,
   output cvsd_pkg::div_stat_type        div_stat
);
   import cvsd_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIVD_W:0]   shifted;
   logic [DIVD_W:0]   diff;
   logic              ge;

   // one restoring step a cycle: remainder starts below the divisor
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         den_in  = dividend + DIV_BIAS;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVD_W-1:0] : shifted[DIVD_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_stat.done = done_ff;
   assign div_stat.quo  = quo_ff;

endmodule

@@ hw/rtl/cvsd_decoder_top.sv @@
`timescale 1ns / 1ps
// a word with an active clock edge runs leak, step and gain (three passes through the shared
// multiplier), then the 15-step divider, and is answered from the finish state
// any other word goes straight to the finish state; the next word waits for the return to idle
// a new word is taken while the previous result still waits in the output register
// reset is synchronous: sequencer, history, step, integrator and sample clear; CSRs get defaults
module cvsd_decoder_top #(
   parameter int HISTORY_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cvsd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cvsd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [cvsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cvsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cvsd_pkg::*;

   state_type state_ff, state_in;

   logic                    active_high_ff, active_high_in;
   logic [7:0]              run_mask_ff, run_mask_in;
   logic [15:0]             charge_coeff_ff, charge_coeff_in;
   logic [15:0]             decay_coeff_ff, decay_coeff_in;
   logic [15:0]             leak_coeff_ff, leak_coeff_in;

   logic                    last_clock_ff, last_clock_in;
   logic                    held_bit_ff, held_bit_in;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [INT_W-1:0]        integ_ff, integ_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;

   logic [MUL_A_W-1:0]      mag_ff, mag_in;
   logic                    sneg_ff, sneg_in;
   logic                    do_charge_ff, do_charge_in;
   logic                    edge_ff, edge_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   mul_req_type             mul_req;
   logic [PROD_W-1:0]       prod;
   logic                    div_start;
   div_stat_type            div_stat;

   logic                    accept;
   logic                    is_edge;
   logic                    out_free;
   logic [HISTORY_BITS-1:0] hist_shift;
   logic [HISTORY_BITS-1:0] hist_masked;
   logic                    charge_now;
   logic [INT_W:0]          sum;
   logic [INT_W:0]          sum_neg;
   logic [INT_W-1:0]        leaked;
   logic [INT_W-1:0]        integ_abs;
   logic [STEP_W-1:0]       step_diff;
   logic [STEP_W-1:0]       step_prod;
   logic [SAMPLE_W-1:0]     quo_ext;

   cvsd_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   cvsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[DIVD_W-1:0]),
      .div_stat (div_stat)
   );

   // ---------------- handshake and shared datapath terms ----------------
   always_comb begin
      accept   = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      is_edge  = (req_data.cmd == CMD_CLOCK) &&
                 (active_high_ff ? (!last_clock_ff && req_data.level)
                                 : (last_clock_ff && !req_data.level));

      hist_shift  = {hist_ff[HISTORY_BITS-2:0], held_bit_ff};
      hist_masked = hist_shift & run_mask_ff[HISTORY_BITS-1:0];
      charge_now  = (hist_masked == '0) || (hist_masked == run_mask_ff[HISTORY_BITS-1:0]);

      // integrator moved by the old step, one bit of headroom
      sum     = held_bit_ff ? ({integ_ff[INT_W-1], integ_ff} + {8'd0, step_ff})
                            : ({integ_ff[INT_W-1], integ_ff} - {8'd0, step_ff});
      sum_neg = (INT_W+1)'(0) - sum;

      leaked    = prod[PROD_W-1:16];
      integ_abs = integ_ff[INT_W-1] ? (INT_W'(0) - integ_ff) : integ_ff;
      step_diff = STEP_MAX - step_ff;
      step_prod = prod[STEP_W+15:16];
      quo_ext   = {1'b0, div_stat.quo};
   end

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_edge ? ST_LEAK : ST_FINISH;
            end
         end
         ST_LEAK:      state_in = ST_STEP;
         ST_STEP:      state_in = ST_GAIN;
         ST_GAIN:      state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      mul_req.en  = 1'b0;
      mul_req.a   = mag_ff;
      mul_req.b   = leak_coeff_ff;
      div_start   = 1'b0;
      case (state_ff)
         ST_LEAK: begin
            mul_req.en = 1'b1;
         end
         ST_STEP: begin
            mul_req.en = 1'b1;
            if (do_charge_ff) begin
               mul_req.a = {7'd0, step_diff};
               mul_req.b = charge_coeff_ff;
            end else begin
               mul_req.a = {7'd0, step_ff};
               mul_req.b = decay_coeff_ff;
            end
         end
         ST_GAIN: begin
            mul_req.en = 1'b1;
            mul_req.a  = integ_abs;
            mul_req.b  = GAIN_K;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------- register next values ----------------
   always_comb begin
      active_high_in  = active_high_ff;
      run_mask_in     = run_mask_ff;
      charge_coeff_in = charge_coeff_ff;
      decay_coeff_in  = decay_coeff_ff;
      leak_coeff_in   = leak_coeff_ff;
      last_clock_in   = last_clock_ff;
      held_bit_in     = held_bit_ff;
      hist_in         = hist_ff;
      step_in         = step_ff;
      integ_in        = integ_ff;
      sample_in       = sample_ff;
      mag_in          = mag_ff;
      sneg_in         = sneg_ff;
      do_charge_in    = do_charge_ff;
      edge_in         = edge_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_HIGH:  active_high_in  = csr_wdata[0];
            CSR_RUN_MASK:     run_mask_in     = csr_wdata[7:0];
            CSR_CHARGE_COEFF: charge_coeff_in = csr_wdata;
            CSR_DECAY_COEFF:  decay_coeff_in  = csr_wdata;
            CSR_LEAK_COEFF:   leak_coeff_in   = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               edge_in      = is_edge;
               sneg_in      = sum[INT_W];
               mag_in       = sum[INT_W] ? sum_neg[INT_W-1:0] : sum[INT_W-1:0];
               do_charge_in = charge_now;
               if (req_data.cmd == CMD_DATA) begin
                  held_bit_in = req_data.level;
               end else begin
                  last_clock_in = req_data.level;
                  if (is_edge) begin
                     hist_in = hist_shift;
                  end
               end
            end
         end
         ST_STEP: begin
            // leaked magnitude back to signed, saturated to 24 bits
            if (!sneg_ff) begin
               integ_in = (leaked > INT_POS_MAX) ? INT_POS_MAX : leaked;
            end else begin
               integ_in = (leaked > INT_NEG_LIM) ? INT_NEG_LIM : (INT_W'(0) - leaked);
            end
         end
         ST_GAIN: begin
            if (do_charge_ff) begin
               step_in = (step_ff > STEP_MAX) ? STEP_MAX : (STEP_MAX - step_prod);
            end else begin
               step_in = (step_prod < STEP_MIN) ? STEP_MIN : step_prod;
            end
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               sample_in = integ_ff[INT_W-1] ? (SAMPLE_W'(0) - quo_ext) : quo_ext;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.sample  = sample_ff;
               rsp_data_in.updated = edge_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_high_ff  <= RST_ACTIVE_HIGH;
         run_mask_ff     <= RST_RUN_MASK;
         charge_coeff_ff <= RST_CHARGE_COEFF;
         decay_coeff_ff  <= RST_DECAY_COEFF;
         leak_coeff_ff   <= RST_LEAK_COEFF;
         last_clock_ff   <= 1'b0;
         held_bit_ff     <= 1'b0;
         hist_ff         <= '0;
         step_ff         <= '0;
         integ_ff        <= '0;
         sample_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_high_ff  <= active_high_in;
         run_mask_ff     <= run_mask_in;
         charge_coeff_ff <= charge_coeff_in;
         decay_coeff_ff  <= decay_coeff_in;
         leak_coeff_ff   <= leak_coeff_in;
         last_clock_ff   <= last_clock_in;
         held_bit_ff     <= held_bit_in;
         hist_ff         <= hist_in;
         step_ff         <= step_in;
         integ_ff        <= integ_in;
         sample_ff       <= sample_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      sneg_ff      <= sneg_in;
      do_charge_ff <= do_charge_in;
      edge_ff      <= edge_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/cvsd_checker.sv @@
`timescale 1ns / 1ps
`include "cvsd_decoder_top_defines.svh"

module cvsd_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  cvsd_pkg::req_type    req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cvsd_pkg::rsp_type    rsp_data
);
   import cvsd_pkg::*;

   logic rsp_wait;
   logic req_take;
   logic data_take;
   logic data_rsp;

   assign rsp_wait  = rsp_valid && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign data_take = req_take && (req_data.cmd == CMD_DATA) && !rsp_valid;
   assign data_rsp  = rsp_valid && !rsp_data.updated;

   // result word held while stalled
   `CVSD_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid, "rsp dropped under stall")
   `CVSD_ASSERT_NEXT(a_rsp_stable, rsp_wait, $stable(rsp_data), "rsp changed under stall")

   // block is busy right after taking a word
   `CVSD_ASSERT_NEXT(a_busy_after_accept, req_take, req_stall, "accepted back to back")

   // a data-bit word taken with the output slot empty passes through the finish state and gives a non-updated result
   `CVSD_ASSERT(a_data_word_result, data_take |=> ##1 data_rsp, "data word result missing")

endmodule

bind cvsd_decoder_top cvsd_checker u_cvsd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
